@@ hw/rtl/lsc_pkg.sv @@
// Shared constants and types for the line segment clipper.
// Used by the channel interfaces, the register block and the top level.
`default_nettype none

package lsc_pkg;

   // Default coordinate width; the top level parameter may override it
   localparam int COORD_WIDTH_DEF = 16;

   // Register port: 32-bit data, four registers at byte addresses 0, 4, 8, 12
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 4;

   typedef enum logic [1:0] {
      REG_X_MIN = 2'd0,
      REG_Y_MIN = 2'd1,
      REG_X_MAX = 2'd2,
      REG_Y_MAX = 2'd3
   } csr_index_type;

   localparam int WIN_X_MIN_RESET = 100;
   localparam int WIN_Y_MIN_RESET = 100;
   localparam int WIN_X_MAX_RESET = 500;
   localparam int WIN_Y_MAX_RESET = 300;

   // Outcode bit positions
   localparam int OC_LEFT   = 0;
   localparam int OC_RIGHT  = 1;
   localparam int OC_BOTTOM = 2;
   localparam int OC_TOP    = 3;

   typedef logic [3:0] outcode_type;

   localparam int MAX_ROUNDS  = 4;
   localparam int ROUND_WIDTH = 3;

endpackage

`default_nettype wire

@@ hw/rtl/lsc_channels.sv @@
// Valid/ready channel interfaces for the clipper's request and result streams.
// Depends on lsc_pkg for the default coordinate width.
`default_nettype none

interface lsc_req_if #(
   parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsc_rsp_if #(
   parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          accepted;
   logic signed [COORD_WIDTH-1:0] clipped_start_x;
   logic signed [COORD_WIDTH-1:0] clipped_start_y;
   logic signed [COORD_WIDTH-1:0] clipped_end_x;
   logic signed [COORD_WIDTH-1:0] clipped_end_y;

   modport source (output valid, accepted, clipped_start_x, clipped_start_y,
                   clipped_end_x, clipped_end_y, input ready);
   modport sink   (input valid, accepted, clipped_start_x, clipped_start_y,
                   clipped_end_x, clipped_end_y, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/line_segment_clipper_unit.sv @@
// Line segment clipper, top level: Cohen-Sutherland clipping sequencer.
// Depends on lsc_pkg, lsc_channels, lsc_csr and lsc_muldiv.
//
// Usage:
//   req_if  carries one segment per request (start_x/y, end_x/y, signed).
//   rsp_if  returns one result per request: accepted flag and the clipped
//           endpoints; all coordinates are zero for a rejected segment.
//   csr_*   APB-style port for the clip window: x_min at 0x0, y_min at 0x4,
//           x_max at 0x8, y_max at 0xC. Write only while no request is open.
// Flow:
//   One request is clipped at a time. Each clipping round follows an outcode
//   test and runs the shared bit-serial multiply/divide unit, first its
//   multiply and then its divide. A segment needs zero to four rounds.
//   The finished result sits in an output register, so the next request is
//   taken while the previous result waits; a stalled receiver holds the
//   result and, once a second result is ready, holds the sequencer.
// Reset: synchronous; the window returns to (100,100)-(500,300), both
//   channels go idle and any open request is dropped.
`default_nettype none

module line_segment_clipper_unit #(
   parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   lsc_req_if.sink                                  req_if,
   lsc_rsp_if.source                                rsp_if,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [lsc_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [lsc_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic      [lsc_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                     csr_pready
);
   import lsc_pkg::*;

   localparam int W = COORD_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WAIT,
      ST_FINISH
   } state_type;

   state_type              state_ff;
   logic [ROUND_WIDTH-1:0] round_ff;
   logic signed [W-1:0]    x1_ff, y1_ff, x2_ff, y2_ff;
   logic                   first_ff;
   logic                   edge_y_ff;
   logic signed [W-1:0]    fixed_ff;
   logic signed [W-1:0]    base_ff;
   logic                   accept_ff;
   logic                   md_start_ff;
   logic signed [W:0]      op_a_ff, op_b_ff, op_d_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_accepted_ff;
   logic signed [W-1:0]    rsp_x1_ff, rsp_y1_ff, rsp_x2_ff, rsp_y2_ff;

   logic signed [W-1:0]    win_x_min, win_y_min, win_x_max, win_y_max;
   outcode_type            c1, c2, co;
   logic                   trivial_in, trivial_out;
   logic                   edge_y;
   logic signed [W-1:0]    edge_val;
   logic                   md_busy, md_done;
   logic [W-1:0]           md_result;
   logic signed [W-1:0]    new_coord;
   logic signed [W-1:0]    nx, ny;
   logic                   rsp_free;

   function automatic outcode_type outcode(
      input logic signed [W-1:0] x,
      input logic signed [W-1:0] y,
      input logic signed [W-1:0] xmin,
      input logic signed [W-1:0] ymin,
      input logic signed [W-1:0] xmax,
      input logic signed [W-1:0] ymax
   );
      outcode_type c;
      c = '0;
      if (x < xmin) begin
         c[OC_LEFT] = 1'b1;
      end else if (x > xmax) begin
         c[OC_RIGHT] = 1'b1;
      end
      if (y < ymin) begin
         c[OC_BOTTOM] = 1'b1;
      end else if (y > ymax) begin
         c[OC_TOP] = 1'b1;
      end
      return c;
   endfunction

   function automatic logic signed [W:0] sdiff(
      input logic signed [W-1:0] p,
      input logic signed [W-1:0] q
   );
      return {p[W-1], p} - {q[W-1], q};
   endfunction

   lsc_csr #(.COORD_WIDTH(W)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .win_x_min   (win_x_min),
      .win_y_min   (win_y_min),
      .win_x_max   (win_x_max),
      .win_y_max   (win_y_max)
   );

   lsc_muldiv #(.COORD_WIDTH(W)) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (md_start_ff),
      .op_a   (op_a_ff),
      .op_b   (op_b_ff),
      .op_d   (op_d_ff),
      .busy   (md_busy),
      .done   (md_done),
      .result (md_result)
   );

   assign c1 = outcode(x1_ff, y1_ff, win_x_min, win_y_min, win_x_max, win_y_max);
   assign c2 = outcode(x2_ff, y2_ff, win_x_min, win_y_min, win_x_max, win_y_max);
   assign co = (c1 != '0) ? c1 : c2;

   assign trivial_in  = (c1 == '0) && (c2 == '0);
   assign trivial_out = ((c1 & c2) != '0) || (round_ff == ROUND_WIDTH'(MAX_ROUNDS));

   // Edge priority: top, bottom, right, left
   assign edge_y   = co[OC_TOP] || co[OC_BOTTOM];
   assign edge_val = co[OC_TOP]    ? win_y_max :
                     co[OC_BOTTOM] ? win_y_min :
                     co[OC_RIGHT]  ? win_x_max : win_x_min;

   assign new_coord = base_ff + $signed(md_result);
   assign nx = edge_y_ff ? new_coord : fixed_ff;
   assign ny = edge_y_ff ? fixed_ff  : new_coord;

   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         md_start_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         md_start_ff <= (state_ff == ST_CHECK) && !trivial_in && !trivial_out;
         // load a new result, or drop the one just taken
         if (state_ff == ST_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  x1_ff    <= req_if.start_x;
                  y1_ff    <= req_if.start_y;
                  x2_ff    <= req_if.end_x;
                  y2_ff    <= req_if.end_y;
                  round_ff <= '0;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (trivial_in) begin
                  accept_ff <= 1'b1;
                  state_ff  <= ST_FINISH;
               end else if (trivial_out) begin
                  accept_ff <= 1'b0;
                  state_ff  <= ST_FINISH;
               end else begin
                  // new point on the edge, measured from the first endpoint
                  op_a_ff     <= edge_y ? sdiff(x2_ff, x1_ff) : sdiff(y2_ff, y1_ff);
                  op_b_ff     <= edge_y ? sdiff(edge_val, y1_ff) : sdiff(edge_val, x1_ff);
                  op_d_ff     <= edge_y ? sdiff(y2_ff, y1_ff) : sdiff(x2_ff, x1_ff);
                  base_ff     <= edge_y ? x1_ff : y1_ff;
                  fixed_ff    <= edge_val;
                  edge_y_ff   <= edge_y;
                  first_ff    <= (c1 != '0);
                  state_ff    <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               if (md_done) begin
                  if (first_ff) begin
                     x1_ff <= nx;
                     y1_ff <= ny;
                  end else begin
                     x2_ff <= nx;
                     y2_ff <= ny;
                  end
                  round_ff <= round_ff + 1'b1;
                  state_ff <= ST_CHECK;
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  rsp_accepted_ff <= accept_ff;
                  rsp_x1_ff       <= accept_ff ? x1_ff : '0;
                  rsp_y1_ff       <= accept_ff ? y1_ff : '0;
                  rsp_x2_ff       <= accept_ff ? x2_ff : '0;
                  rsp_y2_ff       <= accept_ff ? y2_ff : '0;
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_if.ready = (state_ff == ST_IDLE);

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.accepted        = rsp_accepted_ff;
   assign rsp_if.clipped_start_x = rsp_x1_ff;
   assign rsp_if.clipped_start_y = rsp_y1_ff;
   assign rsp_if.clipped_end_x   = rsp_x2_ff;
   assign rsp_if.clipped_end_y   = rsp_y2_ff;

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      round_ff <= ROUND_WIDTH'(MAX_ROUNDS))
      else $error("clip round counter past its limit");

   a_accept_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && accept_ff) |-> (c1 == '0 && c2 == '0))
      else $error("accepted segment has an endpoint outside the window");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_accepted_ff) |->
         (rsp_x1_ff == '0 && rsp_y1_ff == '0 && rsp_x2_ff == '0 && rsp_y2_ff == '0))
      else $error("rejected result carries nonzero coordinates");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      md_start_ff |-> !md_busy)
      else $error("divider started while busy");

   a_wait_busy: assert property (@(posedge clock) disable iff (reset)
      md_start_ff |=> (md_busy && state_ff == ST_WAIT))
      else $error("sequencer left the wait state with the divider running");

endmodule

`default_nettype wire

@@ hw/rtl/lsc_csr.sv @@
// Clip window registers behind an APB-style port.
// Depends on lsc_pkg for register indexes, reset values and port widths.
`default_nettype none

module lsc_csr #(
   parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [lsc_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire logic [lsc_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic      [lsc_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                      csr_pready,
   output logic signed [COORD_WIDTH-1:0]             win_x_min,
   output logic signed [COORD_WIDTH-1:0]             win_y_min,
   output logic signed [COORD_WIDTH-1:0]             win_x_max,
   output logic signed [COORD_WIDTH-1:0]             win_y_max
);
   import lsc_pkg::*;

   localparam int W = COORD_WIDTH;

   logic signed [W-1:0] x_min_ff;
   logic signed [W-1:0] y_min_ff;
   logic signed [W-1:0] x_max_ff;
   logic signed [W-1:0] y_max_ff;
   logic                wr_en;
   csr_index_type       index;
   logic signed [W-1:0] rd_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff <= W'(WIN_X_MIN_RESET);
         y_min_ff <= W'(WIN_Y_MIN_RESET);
         x_max_ff <= W'(WIN_X_MAX_RESET);
         y_max_ff <= W'(WIN_Y_MAX_RESET);
      end else if (wr_en) begin
         case (index)
            REG_X_MIN: x_min_ff <= csr_pwdata[W-1:0];
            REG_Y_MIN: y_min_ff <= csr_pwdata[W-1:0];
            REG_X_MAX: x_max_ff <= csr_pwdata[W-1:0];
            REG_Y_MAX: y_max_ff <= csr_pwdata[W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_X_MIN: rd_sel = x_min_ff;
         REG_Y_MIN: rd_sel = y_min_ff;
         REG_X_MAX: rd_sel = x_max_ff;
         REG_Y_MAX: rd_sel = y_max_ff;
         default:   rd_sel = x_min_ff;
      endcase
   end

   // Sign-extend to the bus width
   assign csr_prdata = CSR_DATA_WIDTH'(rd_sel);

   assign win_x_min = x_min_ff;
   assign win_y_min = y_min_ff;
   assign win_x_max = x_max_ff;
   assign win_y_max = y_max_ff;

endmodule

`default_nettype wire

@@ hw/rtl/lsc_muldiv.sv @@
// Bit-serial (a * b) / d unit, quotient truncated toward zero, wrapped to
// the coordinate width. Shift-add multiply, then restoring radix-2 divide.
`default_nettype none

module lsc_muldiv #(
   parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic signed [COORD_WIDTH:0]     op_a,
   input  wire logic signed [COORD_WIDTH:0]     op_b,
   input  wire logic signed [COORD_WIDTH:0]     op_d,
   output logic                                 busy,
   output logic                                 done,
   output logic             [COORD_WIDTH-1:0]   result
);

   localparam int W  = COORD_WIDTH;
   localparam int PW = 2 * W;
   localparam int CW = $clog2(PW);

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } md_state_type;

   md_state_type     state_ff;
   logic [CW-1:0]    cnt_ff;
   logic [W-1:0]     ma_ff;
   logic [W-1:0]     md_ff;
   logic [W-1:0]     rem_ff;
   logic [PW-1:0]    prod_ff;
   logic             neg_ff;
   logic             zero_ff;
   logic             done_ff;
   logic [W-1:0]     result_ff;

   logic [W:0]       mul_sum;
   logic [W:0]       div_trial;
   logic [W:0]       div_diff;
   logic             div_ge;
   logic [W-1:0]     quot;

   function automatic logic [W-1:0] mag(input logic signed [W:0] v);
      logic [W:0] n;
      n = v[W] ? -v : v;
      return n[W-1:0];
   endfunction

   assign mul_sum   = {1'b0, prod_ff[PW-1:W]} + (prod_ff[0] ? {1'b0, ma_ff} : '0);
   assign div_trial = {rem_ff, prod_ff[PW-1]};
   assign div_diff  = div_trial - {1'b0, md_ff};
   assign div_ge    = div_trial >= {1'b0, md_ff};
   assign quot      = {prod_ff[W-2:0], div_ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == MD_DIV) && (cnt_ff == CW'(PW - 1));
         case (state_ff)
            MD_IDLE: begin
               if (start) begin
                  ma_ff    <= mag(op_a);
                  md_ff    <= mag(op_d);
                  prod_ff  <= {{W{1'b0}}, mag(op_b)};
                  neg_ff   <= op_a[W] ^ op_b[W] ^ op_d[W];
                  zero_ff  <= (op_d == '0);
                  cnt_ff   <= '0;
                  state_ff <= MD_MUL;
               end
            end
            MD_MUL: begin
               prod_ff <= {mul_sum, prod_ff[W-1:1]};
               if (cnt_ff == CW'(W - 1)) begin
                  cnt_ff   <= '0;
                  rem_ff   <= '0;
                  state_ff <= MD_DIV;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            MD_DIV: begin
               // shift the dividend out at the top, quotient bits in at the bottom
               prod_ff <= {prod_ff[PW-2:0], div_ge};
               rem_ff  <= div_ge ? div_diff[W-1:0] : div_trial[W-1:0];
               if (cnt_ff == CW'(PW - 1)) begin
                  result_ff <= zero_ff ? '0 : (neg_ff ? -quot : quot);
                  state_ff  <= MD_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            default: state_ff <= MD_IDLE;
         endcase
      end
   end

   assign busy   = (state_ff != MD_IDLE);
   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

@@ tb/sv/line_segment_clipper_unit_tb.sv @@
// Self-checking testbench for the line segment clipper: directed and random
// segments against several clip windows, checked against pinned results or an in-bench predictor.
// Depends on lsc_pkg, lsc_channels and the line_segment_clipper_unit RTL.
`default_nettype none

module line_segment_clipper_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lsc_pkg::*;

   localparam int CW              = COORD_WIDTH_DEF;
   localparam int ITEMS_PER_PHASE = 59;
   localparam int NUM_PHASES      = 9;
   localparam int STALL_LIMIT     = 4000;
   localparam int TAIL_CYCLES     = 250;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
   } segment_type;

   typedef struct packed {
      logic      accepted;
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
   } clip_result_type;

   typedef struct {
      int sx, sy, ex, ey;
      bit pinned;
      bit acc;
      int rsx, rsy, rex, rey;
   } directed_row_type;

   typedef struct {
      int x_min, y_min, x_max, y_max;
   } window_type;

   logic clock = 1'b0;
   logic reset;

   lsc_req_if #(.COORD_WIDTH(CW)) req_if ();
   lsc_rsp_if #(.COORD_WIDTH(CW)) rsp_if ();

   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   logic result_ready = 1'b0;
   assign rsp_if.ready = result_ready;

   line_segment_clipper_unit #(.COORD_WIDTH(CW)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Window as the block should hold it
   coord_type win_x_min = coord_type'(WIN_X_MIN_RESET);
   coord_type win_y_min = coord_type'(WIN_Y_MIN_RESET);
   coord_type win_x_max = coord_type'(WIN_X_MAX_RESET);
   coord_type win_y_max = coord_type'(WIN_Y_MAX_RESET);

   clip_result_type pending_clips[$];
   bit              req_pinned = 1'b0;
   clip_result_type req_pinned_result = '0;
   bit              steady_flow = 1'b0;
   int              mismatches = 0;
   int              segments_sent = 0;
   int              results_checked = 0;
   int              stall_cycles = 0;

   // All rows run under the reset window; rows with pinned results are read off by hand
   directed_row_type directed_rows [25] = '{
      '{200, 150, 400, 250, 1, 1, 200, 150, 400, 250},
      '{100, 100, 500, 300, 1, 1, 100, 100, 500, 300},
      '{250, 250, 250, 250, 1, 1, 250, 250, 250, 250},
      '{0, 150, 50, 250, 1, 0, 0, 0, 0, 0},
      '{600, 150, 700, 250, 1, 0, 0, 0, 0, 0},
      '{200, 0, 400, 50, 1, 0, 0, 0, 0, 0},
      '{200, 400, 400, 350, 1, 0, 0, 0, 0, 0},
      '{99, 100, 99, 300, 1, 0, 0, 0, 0, 0},
      '{501, 120, 501, 280, 1, 0, 0, 0, 0, 0},
      '{600, 600, 600, 600, 1, 0, 0, 0, 0, 0},
      '{-32768, -32768, -32768, 32767, 1, 0, 0, 0, 0, 0},
      '{32767, 32767, 32767, -32768, 1, 0, 0, 0, 0, 0},
      '{-32768, 32767, 32767, 32767, 1, 0, 0, 0, 0, 0},
      '{0, 200, 600, 200, 1, 1, 100, 200, 500, 200},
      '{300, 0, 300, 400, 1, 1, 300, 100, 300, 300},
      '{-32768, -32768, 32767, 32767, 0, 0, 0, 0, 0, 0},
      '{32767, -32768, -32768, 32767, 0, 0, 0, 0, 0, 0},
      '{0, 0, 600, 400, 0, 0, 0, 0, 0, 0},
      '{0, 50, 600, 450, 0, 0, 0, 0, 0, 0},
      '{0, 290, 150, 400, 0, 0, 0, 0, 0, 0},
      '{450, 350, 700, 150, 0, 0, 0, 0, 0, 0},
      '{600, 200, 200, 200, 0, 0, 0, 0, 0, 0},
      '{150, 200, 800, -400, 0, 0, 0, 0, 0, 0},
      '{-32768, 200, 32767, 200, 0, 0, 0, 0, 0, 0},
      '{0, 95, 1000, 305, 0, 0, 0, 0, 0, 0}
   };

   window_type phase_windows [NUM_PHASES] = '{
      '{100, 100, 500, 300},
      '{-32768, -32768, 32767, 32767},
      '{0, 0, 0, 0},
      '{-1000, -800, -10, -5},
      '{200, 50, -200, -50},
      '{32000, -32768, 32767, -32000},
      '{0, 0, 0, 0},
      '{0, 0, 0, 0},
      '{100, 100, 500, 300}
   };

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint wrap_coord(input longint v);
      return longint'(coord_type'(v));
   endfunction

   function automatic outcode_type region_code(input longint x, input longint y);
      outcode_type c;
      c = '0;
      if (x < longint'(win_x_min))
         c[OC_LEFT] = 1'b1;
      else if (x > longint'(win_x_max))
         c[OC_RIGHT] = 1'b1;
      if (y < longint'(win_y_min))
         c[OC_BOTTOM] = 1'b1;
      else if (y > longint'(win_y_max))
         c[OC_TOP] = 1'b1;
      return c;
   endfunction

   // Exact product over a difference, truncated toward zero
   function automatic longint scaled_offset(input longint a, input longint b,
                                            input longint d);
      if (d == 0)
         return 0;
      return (a * b) / d;
   endfunction

   function automatic clip_result_type clip_segment(input segment_type seg);
      longint          x1, y1, x2, y2, nx, ny;
      longint          xmin, ymin, xmax, ymax;
      outcode_type     c1, c2, co;
      bit              accept;
      clip_result_type r;
      x1 = $signed(seg.sx);
      y1 = $signed(seg.sy);
      x2 = $signed(seg.ex);
      y2 = $signed(seg.ey);
      xmin = win_x_min;
      ymin = win_y_min;
      xmax = win_x_max;
      ymax = win_y_max;
      c1 = region_code(x1, y1);
      c2 = region_code(x2, y2);
      accept = 1'b0;
      for (int round = 0; round <= MAX_ROUNDS; round++) begin
         if (c1 == 0 && c2 == 0) begin
            accept = 1'b1;
            break;
         end
         if ((c1 & c2) != 0 || round == MAX_ROUNDS)
            break;
         co = (c1 != 0) ? c1 : c2;
         if (co[OC_TOP]) begin
            ny = ymax;
            nx = wrap_coord(x1 + scaled_offset(x2 - x1, ymax - y1, y2 - y1));
         end else if (co[OC_BOTTOM]) begin
            ny = ymin;
            nx = wrap_coord(x1 + scaled_offset(x2 - x1, ymin - y1, y2 - y1));
         end else if (co[OC_RIGHT]) begin
            nx = xmax;
            ny = wrap_coord(y1 + scaled_offset(y2 - y1, xmax - x1, x2 - x1));
         end else begin
            nx = xmin;
            ny = wrap_coord(y1 + scaled_offset(y2 - y1, xmin - x1, x2 - x1));
         end
         if (c1 != 0) begin
            x1 = nx;
            y1 = ny;
            c1 = region_code(x1, y1);
         end else begin
            x2 = nx;
            y2 = ny;
            c2 = region_code(x2, y2);
         end
      end
      r.accepted = accept;
      r.sx = accept ? coord_type'(x1) : '0;
      r.sy = accept ? coord_type'(y1) : '0;
      r.ex = accept ? coord_type'(x2) : '0;
      r.ey = accept ? coord_type'(y2) : '0;
      return r;
   endfunction

   // Mostly in and around the window range, some full range, some corner values
   function automatic coord_type rand_coord(input longint lo, input longint hi);
      longint base, span, v;
      int     pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         base = (lo < hi) ? lo : hi;
         span = ((hi > lo) ? hi - lo : lo - hi) + 64;
         v = base - span / 2 + longint'($urandom_range(0, 32'(2 * span)));
      end else if (pick < 80) begin
         v = longint'($urandom());
      end else begin
         case ($urandom_range(0, 7))
            0: v = -32768;
            1: v = 32767;
            2: v = 0;
            3: v = -1;
            4: v = lo;
            5: v = hi;
            6: v = lo - 1;
            default: v = hi + 1;
         endcase
      end
      return coord_type'(v);
   endfunction

   task automatic check_field(input string label, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         mismatches++;
      end
   endtask

   // Write one window register, then read it back
   task automatic csr_write(input csr_index_type idx, input coord_type value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {{(CSR_DATA_WIDTH-CW){value[CW-1]}}, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_X_MIN: win_x_min = value;
         REG_Y_MIN: win_y_min = value;
         REG_X_MAX: win_x_max = value;
         default:   win_y_max = value;
      endcase
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      check_field("window readback", value, $signed(csr_prdata[CW-1:0]));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_segment(input segment_type seg, input bit pinned,
                               input clip_result_type pinned_res);
      while (!steady_flow && $urandom_range(0, 99) < 38) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.start_x <= seg.sx;
      req_if.start_y <= seg.sy;
      req_if.end_x   <= seg.ex;
      req_if.end_y   <= seg.ey;
      req_pinned        = pinned;
      req_pinned_result = pinned_res;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      @(negedge clock);
      segments_sent++;
   endtask

   // Drop valid and hold until every expected result is back
   task automatic hold_until_drained();
      req_if.valid <= 1'b0;
      do
         @(negedge clock);
      while (pending_clips.size() != 0);
   endtask

   always @(negedge clock) begin
      result_ready <= steady_flow || ($urandom_range(0, 99) >= 38);
   end

   always @(posedge clock) begin : result_monitor
      clip_result_type want;
      segment_type     seen;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            seen = '{req_if.start_x, req_if.start_y, req_if.end_x, req_if.end_y};
            pending_clips.push_back(req_pinned ? req_pinned_result : clip_segment(seen));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_clips.size() == 0) begin
               $display("%0t: result with no request open, actual %0d (%0d,%0d)-(%0d,%0d)",
                        $time, rsp_if.accepted, rsp_if.clipped_start_x,
                        rsp_if.clipped_start_y, rsp_if.clipped_end_x, rsp_if.clipped_end_y);
               mismatches++;
            end else begin
               want = pending_clips.pop_front();
               check_field("accepted", want.accepted, rsp_if.accepted);
               check_field("clipped_start_x", $signed(want.sx), rsp_if.clipped_start_x);
               check_field("clipped_start_y", $signed(want.sy), rsp_if.clipped_start_y);
               check_field("clipped_end_x", $signed(want.ex), rsp_if.clipped_end_x);
               check_field("clipped_end_y", $signed(want.ey), rsp_if.clipped_end_y);
               results_checked++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || csr_psel) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d results outstanding",
                  $time, stall_cycles, pending_clips.size());
         $display("line_segment_clipper_unit_tb: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      directed_row_type row;
      segment_type      seg;
      clip_result_type  res;
      window_type       w;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.start_x = '0;
      req_if.start_y = '0;
      req_if.end_x   = '0;
      req_if.end_y   = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         seg = '{coord_type'(row.sx), coord_type'(row.sy), coord_type'(row.ex),
                 coord_type'(row.ey)};
         res = '{row.acc, coord_type'(row.rsx), coord_type'(row.rsy),
                 coord_type'(row.rex), coord_type'(row.rey)};
         send_segment(seg, row.pinned, res);
      end

      for (int i = 6; i < 8; i++) begin
         phase_windows[i].x_min = int'($urandom_range(0, 20000)) - 10000;
         phase_windows[i].y_min = int'($urandom_range(0, 20000)) - 10000;
         phase_windows[i].x_max = phase_windows[i].x_min + int'($urandom_range(0, 3000));
         phase_windows[i].y_max = phase_windows[i].y_min + int'($urandom_range(0, 3000));
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         hold_until_drained();
         // The first phase keeps the window from reset
         if (p != 0) begin
            w = phase_windows[p];
            csr_write(REG_X_MIN, coord_type'(w.x_min));
            csr_write(REG_Y_MIN, coord_type'(w.y_min));
            csr_write(REG_X_MAX, coord_type'(w.x_max));
            csr_write(REG_Y_MAX, coord_type'(w.y_max));
         end
         steady_flow = (p == 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (p == 3 && n == ITEMS_PER_PHASE / 2)
               hold_until_drained();
            seg.sx = rand_coord(win_x_min, win_x_max);
            seg.sy = rand_coord(win_y_min, win_y_max);
            seg.ex = rand_coord(win_x_min, win_x_max);
            seg.ey = rand_coord(win_y_min, win_y_max);
            send_segment(seg, 1'b0, '0);
         end
      end
      steady_flow = 1'b0;

      hold_until_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Clipped %0d segments, %0d results checked, over %0d windows", segments_sent,
               results_checked, NUM_PHASES);
      $display("Windows: reset, full range, single point, negative, inverted, range edge, random");
      if (mismatches == 0) begin
         $display("line_segment_clipper_unit_tb: done, clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("line_segment_clipper_unit_tb: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/lsc_pkg.sv
hw/rtl/lsc_channels.sv
hw/rtl/lsc_csr.sv
hw/rtl/lsc_muldiv.sv
hw/rtl/line_segment_clipper_unit.sv
tb/sv/line_segment_clipper_unit_tb.sv
